// ===== hdl/ncvs_pkg.sv =====
// Package for the Newton cubic velocity solver: widths, codes and helpers.
// Used by every module of the block; depends on nothing.
package ncvs_pkg;

  localparam int unsigned WORD_BITS_DEF = 32;
  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned IO_BITS       = 32;
  localparam int unsigned TOL_BITS      = 16;
  localparam int unsigned ITER_BITS     = 7;
  localparam int unsigned STATUS_BITS   = 2;
  localparam int unsigned ADDR_BITS     = 1;
  localparam int unsigned ITER_CAP      = 64;

  localparam logic [ADDR_BITS-1:0] REG_TOLERANCE = 1'd0;
  localparam logic [ADDR_BITS-1:0] REG_MAX_ITER  = 1'd1;

  localparam logic [STATUS_BITS-1:0] ST_CONVERGED = 2'd0;
  localparam logic [STATUS_BITS-1:0] ST_LIMIT     = 2'd1;
  localparam logic [STATUS_BITS-1:0] ST_ZERO_DERIV = 2'd2;

  localparam logic [TOL_BITS-1:0]  TOL_RESET  = 16'd1;
  localparam logic [ITER_BITS-1:0] ITER_RESET = 7'd32;

  typedef struct packed {
    logic [IO_BITS-1:0] distance;
    logic [IO_BITS-1:0] start_velocity;
    logic [IO_BITS-1:0] jerk;
    logic [IO_BITS-1:0] initial_guess;
  } in_item_t;

  typedef struct packed {
    logic [IO_BITS-1:0]     root;
    logic [STATUS_BITS-1:0] status;
    logic [ITER_BITS-1:0]   iterations_used;
  } out_item_t;

  typedef struct packed {
    logic [ADDR_BITS-1:0] index;
    logic [IO_BITS-1:0]   data;
  } cfg_item_t;

endpackage

// ===== hdl/ncvs_if.sv =====
// Valid/ready channel interface carrying one payload of a given type.
// The payload type is given as a parameter; the interface does not use ncvs_pkg.
interface ncvs_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== hdl/newton_cubic_velocity_solver.sv =====
// Newton cubic velocity solver top level: sequencer, ALU steps and channels.
// Depends on ncvs_pkg, ncvs_if, ncvs_mul and ncvs_div.
//
// Use: an item on in_ch carries distance, start_velocity, jerk and an initial
// guess (signed Q16.16). The block solves sc - 4*I*v - 2*J*v^3 = 0 by Newton
// iteration and returns one item on out_ch: the root, a status code and the
// number of updates applied. cfg_ch writes tolerance (index 0) and
// max_iterations (index 1); other indexes are ignored.
// Each iteration runs five products (v^2, v^3, I*v, J*v^3, J*v^2) on the
// bit-serial multiplier, a zero derivative check, and one division on the
// bit-serial divider followed by the step check.
// One item is in work at a time; in_ch is not ready until the result is taken.
// If out_ch stalls, the result is held in the output register.
// Reset returns tolerance to 1, max_iterations to 32 and the sequencer to idle.
module newton_cubic_velocity_solver import ncvs_pkg::*; #(
  parameter int unsigned WORD_BITS = WORD_BITS_DEF,
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input logic clk_i,
  input logic rst_ni,
  ncvs_if.sink   in_ch,
  ncvs_if.sink   cfg_ch,
  ncvs_if.source out_ch
);
  localparam int unsigned LW = IO_BITS + WORD_BITS;

  typedef logic signed [WORD_BITS-1:0] w_t;
  typedef logic signed [WORD_BITS+3:0] x_t;
  typedef logic signed [LW-1:0]        l_t;

  typedef enum logic [3:0] {
    S_IDLE, S_V2, S_V3, S_A, S_B, S_F, S_JV2, S_D, S_DIV, S_CHK, S_OUT
  } state_e;

  localparam w_t WMAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam w_t WMIN = {1'b1, {(WORD_BITS-1){1'b0}}};
  localparam l_t IO_MAX = l_t'({1'b0, {(IO_BITS-1){1'b1}}});
  localparam l_t IO_MIN = -IO_MAX - l_t'(1);

  state_e state_q;
  w_t sc_q, iv_q, jk_q, v_q, v2_q, v3_q, a_q, f_q, d_q;
  logic [TOL_BITS-1:0]  tol_q;
  logic [ITER_BITS-1:0] maxit_q, used_q, limit;
  out_item_t out_q;
  logic      out_valid_q;
  logic      mul_go_q, div_go_q;
  w_t        mul_a_q, mul_b_q;
  logic      mul_done, div_done;
  w_t        mul_p, div_q;
  w_t        step_mag;
  in_item_t  in_p;
  cfg_item_t cfg_p;

  function automatic w_t sat(input x_t x);
    if (x > x_t'(WMAX)) return WMAX;
    if (x < x_t'(WMIN)) return WMIN;
    return x[WORD_BITS-1:0];
  endfunction

  function automatic w_t load(input logic [IO_BITS-1:0] r);
    logic signed [IO_BITS+WORD_BITS-1:0] s;
    s = (IO_BITS+WORD_BITS)'(signed'(r));
    if (s > (IO_BITS+WORD_BITS)'(WMAX)) return WMAX;
    if (s < (IO_BITS+WORD_BITS)'(WMIN)) return WMIN;
    return s[WORD_BITS-1:0];
  endfunction

  function automatic logic [IO_BITS-1:0] to_io(input w_t x);
    l_t s;
    s = l_t'(x);
    if (s > IO_MAX) return IO_MAX[IO_BITS-1:0];
    if (s < IO_MIN) return IO_MIN[IO_BITS-1:0];
    return s[IO_BITS-1:0];
  endfunction

  ncvs_mul #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) u_mul (
    .clk_i, .rst_ni, .start_i(mul_go_q), .a_i(mul_a_q), .b_i(mul_b_q),
    .done_o(mul_done), .p_o(mul_p)
  );
  ncvs_div #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) u_div (
    .clk_i, .rst_ni, .start_i(div_go_q), .n_i(f_q), .d_i(d_q),
    .done_o(div_done), .q_o(div_q)
  );

  assign in_p  = in_ch.payload;
  assign cfg_p = cfg_ch.payload;
  assign limit = (maxit_q > ITER_BITS'(ITER_CAP)) ? ITER_BITS'(ITER_CAP) : maxit_q;
  assign step_mag = div_q[WORD_BITS-1] ? w_t'(~div_q + 1'b1) : div_q;

  assign in_ch.ready   = (state_q == S_IDLE) && !out_valid_q;
  assign cfg_ch.ready  = 1'b1;
  assign out_ch.valid  = out_valid_q;
  assign out_ch.payload = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      mul_go_q    <= 1'b0;
      div_go_q    <= 1'b0;
      tol_q       <= TOL_RESET;
      maxit_q     <= ITER_RESET;
      used_q      <= '0;
    end else begin
      mul_go_q <= 1'b0;
      div_go_q <= 1'b0;
      if (cfg_ch.valid) begin
        case (cfg_p.index)
          REG_TOLERANCE: tol_q   <= cfg_p.data[TOL_BITS-1:0];
          REG_MAX_ITER:  maxit_q <= cfg_p.data[ITER_BITS-1:0];
          default: ;
        endcase
      end
      if (out_valid_q && out_ch.ready) out_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (in_ch.valid && in_ch.ready) begin
            sc_q <= load(in_p.distance);
            iv_q <= load(in_p.start_velocity);
            jk_q <= load(in_p.jerk);
            v_q  <= load(in_p.initial_guess);
            mul_a_q <= load(in_p.initial_guess);
            mul_b_q <= load(in_p.initial_guess);
            mul_go_q <= 1'b1;
            used_q <= '0;
            state_q <= S_V2;
          end
        end
        S_V2: if (mul_done) begin
          v2_q <= mul_p; mul_a_q <= mul_p; mul_b_q <= v_q; mul_go_q <= 1'b1;
          state_q <= S_V3;
        end
        S_V3: if (mul_done) begin
          v3_q <= mul_p; mul_a_q <= iv_q; mul_b_q <= v_q; mul_go_q <= 1'b1;
          state_q <= S_A;
        end
        S_A: if (mul_done) begin
          a_q <= sat(x_t'(mul_p) <<< 2);
          mul_a_q <= jk_q; mul_b_q <= v3_q; mul_go_q <= 1'b1;
          state_q <= S_B;
        end
        S_B: if (mul_done) begin
          // f = (sc - a) - 2*(J*v3), each step saturated.
          f_q <= sat(x_t'(sat(x_t'(sc_q) - x_t'(a_q))) - x_t'(sat(x_t'(mul_p) <<< 1)));
          mul_a_q <= jk_q; mul_b_q <= v2_q; mul_go_q <= 1'b1;
          state_q <= S_JV2;
        end
        S_JV2: if (mul_done) begin
          d_q <= sat(x_t'(sat(-(x_t'(iv_q) <<< 2))) - x_t'(sat(x_t'(mul_p) * x_t'(6))));
          state_q <= S_D;
        end
        S_D: begin
          if (d_q == '0) begin
            out_q <= '{root: to_io(v_q), status: ST_ZERO_DERIV, iterations_used: used_q};
            state_q <= S_OUT;
          end else begin
            div_go_q <= 1'b1;
            state_q <= S_DIV;
          end
        end
        S_DIV: if (div_done) state_q <= S_CHK;
        S_CHK: begin
          if ({1'b0, step_mag} <= (WORD_BITS+1)'(tol_q)) begin
            out_q <= '{root: to_io(v_q), status: ST_CONVERGED, iterations_used: used_q};
            state_q <= S_OUT;
          end else if (used_q >= limit) begin
            out_q <= '{root: to_io(v_q), status: ST_LIMIT, iterations_used: used_q};
            state_q <= S_OUT;
          end else begin
            v_q <= sat(x_t'(v_q) - x_t'(div_q));
            mul_a_q <= sat(x_t'(v_q) - x_t'(div_q));
            mul_b_q <= sat(x_t'(v_q) - x_t'(div_q));
            mul_go_q <= 1'b1;
            used_q <= used_q + 1'b1;
            state_q <= S_V2;
          end
        end
        S_OUT: begin
          out_valid_q <= 1'b1;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= ITER_BITS'(ITER_CAP)) else $error("iteration count beyond cap");
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.status == ST_CONVERGED || out_q.status == ST_LIMIT ||
                     out_q.status == ST_ZERO_DERIV)) else $error("bad status code");
  a_zero_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_go_q |-> (d_q != '0)) else $error("division by zero started");
  a_idle_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_ch.valid && in_ch.ready) |=> (state_q == S_V2)) else $error("accept lost");
endmodule

// ===== hdl/ncvs_mul.sv =====
// Sequential signed fixed-point multiplier: magnitude shift-add, one bit a cycle,
// rounding half away from zero and saturation to the word range. Uses ncvs_pkg.
module ncvs_mul import ncvs_pkg::*; #(
  parameter int unsigned WORD_BITS = WORD_BITS_DEF,
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic signed [WORD_BITS-1:0] a_i,
  input  logic signed [WORD_BITS-1:0] b_i,
  output logic                        done_o,
  output logic signed [WORD_BITS-1:0] p_o
);
  localparam int unsigned PW = 2 * WORD_BITS;
  localparam int unsigned CW = $clog2(WORD_BITS + 1);

  logic [PW-1:0]        acc_q, acc_d;
  logic [WORD_BITS-1:0] am_q, bm_q;
  logic                 neg_q;
  logic [CW-1:0]        cnt_q;
  logic                 busy_q, done_q;
  logic [WORD_BITS-1:0] am, bm;
  logic [PW-1:0]        rnd;
  logic [PW-1:0]        shr;
  logic signed [WORD_BITS-1:0] sat;
  logic [WORD_BITS-1:0] maxpos;

  assign am = a_i[WORD_BITS-1] ? (~a_i + 1'b1) : a_i;
  assign bm = b_i[WORD_BITS-1] ? (~b_i + 1'b1) : b_i;
  assign acc_d = bm_q[0] ? acc_q + ({{WORD_BITS{1'b0}}, am_q} << cnt_q) : acc_q;

  // Final magnitude with rounding; the exact product fits in PW bits.
  assign rnd = acc_q + (PW'(1) << (FRAC_BITS - 1));
  assign shr = rnd >> FRAC_BITS;
  assign maxpos = {1'b0, {(WORD_BITS-1){1'b1}}};
  always_comb begin
    if (neg_q) begin
      if (shr > PW'({1'b1, {(WORD_BITS-1){1'b0}}})) sat = {1'b1, {(WORD_BITS-1){1'b0}}};
      else sat = WORD_BITS'(~shr[WORD_BITS-1:0] + 1'b1);
    end else begin
      if (shr > PW'(maxpos)) sat = maxpos;
      else sat = shr[WORD_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        acc_q  <= '0;
        am_q   <= am;
        bm_q   <= bm;
        neg_q  <= a_i[WORD_BITS-1] ^ b_i[WORD_BITS-1];
      end else if (busy_q) begin
        acc_q <= acc_d;
        bm_q  <= bm_q >> 1;
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(WORD_BITS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign p_o    = sat;

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q)) else $error("multiplier done without work");
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !done_q) else $error("multiplier busy and done together");
endmodule

// ===== hdl/ncvs_div.sv =====
// Sequential restoring divider for (n << FRAC_BITS) / d, truncated toward zero
// and saturated to the word range, one quotient bit a cycle. Uses ncvs_pkg.
module ncvs_div import ncvs_pkg::*; #(
  parameter int unsigned WORD_BITS = WORD_BITS_DEF,
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic signed [WORD_BITS-1:0] n_i,
  input  logic signed [WORD_BITS-1:0] d_i,
  output logic                        done_o,
  output logic signed [WORD_BITS-1:0] q_o
);
  localparam int unsigned NW = WORD_BITS + FRAC_BITS;
  localparam int unsigned CW = $clog2(NW + 1);

  logic [NW-1:0]        num_q, quo_q;
  logic [WORD_BITS:0]   rem_q;
  logic [WORD_BITS-1:0] dm_q;
  logic                 neg_q, busy_q, done_q;
  logic [CW-1:0]        cnt_q;
  logic [WORD_BITS-1:0] nm, dm;
  logic [WORD_BITS:0]   trial;
  logic                 ge;
  logic signed [WORD_BITS-1:0] sat;

  assign nm = n_i[WORD_BITS-1] ? (~n_i + 1'b1) : n_i;
  assign dm = d_i[WORD_BITS-1] ? (~d_i + 1'b1) : d_i;
  assign trial = {rem_q[WORD_BITS-1:0], num_q[NW-1]};
  assign ge = trial >= {1'b0, dm_q};

  always_comb begin
    if (neg_q) begin
      if (quo_q > NW'({1'b1, {(WORD_BITS-1){1'b0}}})) sat = {1'b1, {(WORD_BITS-1){1'b0}}};
      else sat = WORD_BITS'(~quo_q[WORD_BITS-1:0] + 1'b1);
    end else begin
      if (quo_q > NW'({1'b0, {(WORD_BITS-1){1'b1}}})) sat = {1'b0, {(WORD_BITS-1){1'b1}}};
      else sat = quo_q[WORD_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        num_q  <= {nm, {FRAC_BITS{1'b0}}};
        quo_q  <= '0;
        rem_q  <= '0;
        dm_q   <= dm;
        neg_q  <= n_i[WORD_BITS-1] ^ d_i[WORD_BITS-1];
      end else if (busy_q) begin
        rem_q <= ge ? trial - {1'b0, dm_q} : trial;
        quo_q <= {quo_q[NW-2:0], ge};
        num_q <= num_q << 1;
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(NW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign q_o    = sat;

  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q)) else $error("divider done without work");
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !start_i) |-> (rem_q < {1'b0, dm_q})) else $error("remainder out of range");
endmodule
